@@ rtl/spep_pkg.sv @@
// spep_pkg: shared types, codes and defaults for the specialization entry policy
// no dependencies; used by the interfaces, spep_core and the top level

package spep_pkg;

  // parameter defaults
  localparam int unsigned KEY_BITS_DEF   = 64;
  localparam int unsigned PARTS_BITS_DEF = 8;

  // fixed field widths
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned PARTS_FIELD_W = 8;
  localparam int unsigned CFG_IDX_W    = 2;

  // configuration reset values
  localparam logic [WORD_W-1:0] BACKOFF_RESET = 64'd1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t CFG_BACKOFF = 2'd0;
  localparam cfg_idx_t CFG_PARTS   = 2'd1;

  // request types
  typedef enum logic [2:0] {
    REQ_CHOOSE     = 3'd0,
    REQ_MARK_PEND  = 3'd1,
    REQ_MARK_FAIL  = 3'd2,
    REQ_DEFER_FULL = 3'd3,
    REQ_PUBLISH    = 3'd4
  } req_type_e;

  // entry status codes
  localparam logic [1:0] ST_ABSENT  = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;
  localparam logic [1:0] ST_READY   = 2'd3;

  typedef enum logic [1:0] {
    ROUTE_SPECIAL  = 2'd0,
    ROUTE_SYNC     = 2'd1,
    ROUTE_FALLBACK = 2'd2
  } route_e;

  typedef enum logic [2:0] {
    RSN_READY    = 3'd0,
    RSN_NO_PIPE  = 3'd1,
    RSN_NO_RES   = 3'd2,
    RSN_PENDING  = 3'd3,
    RSN_BACKOFF  = 3'd4,
    RSN_QFULL    = 3'd5,
    RSN_ENQUEUE  = 3'd6
  } reason_e;

  typedef enum logic [2:0] {
    PUB_OK         = 3'd0,
    PUB_NOT_PEND   = 3'd1,
    PUB_INCOMPLETE = 3'd2,
    PUB_KEY_MISM   = 3'd3,
    PUB_GEN_MISM   = 3'd4,
    PUB_BAD_TICKET = 3'd5,
    PUB_TICKET_MISM = 3'd6
  } pub_code_e;

  typedef struct packed {
    logic [2:0]               req_type;
    logic [WORD_W-1:0]        req_key;
    logic [WORD_W-1:0]        req_generation;
    logic [WORD_W-1:0]        req_ticket;
    logic [WORD_W-1:0]        now_epoch;
    logic [WORD_W-1:0]        current_gen;
    logic                     pipeline_ready;
    logic                     draw_ready;
    logic                     queue_space;
    logic [PARTS_FIELD_W-1:0] parts_present;
  } req_t;

  typedef struct packed {
    logic [1:0]        route;
    logic [2:0]        reason;
    logic              request_compile;
    logic              accepted;
    logic [2:0]        publish_code;
    logic [WORD_W-1:0] selection_count;
  } rsp_t;

endpackage

@@ rtl/spep_if.sv @@
// spep_if: valid/ready channel interfaces for requests, results and configuration
// depends on spep_pkg for payload types

interface spep_req_if;
  logic           valid;
  logic           ready;
  spep_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spep_rsp_if;
  logic           valid;
  logic           ready;
  spep_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spep_cfg_if;
  logic                             valid;
  logic                             ready;
  spep_pkg::cfg_idx_t               index;
  logic [spep_pkg::WORD_W-1:0]      wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/spep_core.sv @@
// spep_core: entry state registers and the per-request policy logic
// depends on spep_pkg; instantiated by specialization_entry_policy_top

module spep_core #(
  parameter int unsigned KEY_BITS   = spep_pkg::KEY_BITS_DEF,
  parameter int unsigned PARTS_BITS = spep_pkg::PARTS_BITS_DEF,
  localparam int unsigned PCMP_W    = (PARTS_BITS < spep_pkg::PARTS_FIELD_W) ?
                                      PARTS_BITS : spep_pkg::PARTS_FIELD_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  spep_pkg::req_t              req_i,
  input  logic [spep_pkg::WORD_W-1:0] backoff_i,
  input  logic [PCMP_W-1:0]           complete_parts_i,
  output spep_pkg::rsp_t              rsp_o
);

  logic [1:0]                  state_q, state_d;
  logic [KEY_BITS-1:0]         key_q, key_d;
  logic [spep_pkg::WORD_W-1:0] gen_q, gen_d;
  logic [spep_pkg::WORD_W-1:0] ticket_q, ticket_d;
  logic [spep_pkg::WORD_W-1:0] retry_q, retry_d;
  logic [spep_pkg::WORD_W-1:0] sel_q, sel_d;

  logic [KEY_BITS-1:0]         req_key;
  logic                        match;
  logic                        retry_open;
  logic [spep_pkg::WORD_W:0]   retry_sum;
  logic [spep_pkg::WORD_W-1:0] retry_sat;
  logic [spep_pkg::WORD_W-1:0] sel_inc;
  logic                        pub_ok;

  assign req_key   = req_i.req_key[KEY_BITS-1:0];
  assign match     = (state_q != spep_pkg::ST_ABSENT) && (gen_q == req_i.req_generation) &&
                     (key_q == req_key);
  assign retry_open = !match || ((state_q == spep_pkg::ST_FAILED) &&
                                 (req_i.now_epoch >= retry_q));

  // saturating retry epoch
  assign retry_sum = {1'b0, req_i.now_epoch} + {1'b0, backoff_i};
  assign retry_sat = retry_sum[spep_pkg::WORD_W] ? '1 : retry_sum[spep_pkg::WORD_W-1:0];

  // selection epoch skips zero on wrap
  assign sel_inc = (sel_q == '1) ? spep_pkg::WORD_W'(1) : sel_q + spep_pkg::WORD_W'(1);

  always_comb begin
    state_d  = state_q;
    key_d    = key_q;
    gen_d    = gen_q;
    ticket_d = ticket_q;
    retry_d  = retry_q;
    sel_d    = sel_q;
    pub_ok   = 1'b0;
    rsp_o    = '0;

    case (req_i.req_type)
      spep_pkg::REQ_CHOOSE: begin
        if (match && (state_q == spep_pkg::ST_READY)) begin
          rsp_o.route  = spep_pkg::ROUTE_SPECIAL;
          rsp_o.reason = spep_pkg::RSN_READY;
        end else if (!req_i.pipeline_ready) begin
          rsp_o.route  = spep_pkg::ROUTE_SYNC;
          rsp_o.reason = spep_pkg::RSN_NO_PIPE;
        end else if (!req_i.draw_ready) begin
          rsp_o.route  = spep_pkg::ROUTE_SYNC;
          rsp_o.reason = spep_pkg::RSN_NO_RES;
        end else if (match && (state_q == spep_pkg::ST_PENDING)) begin
          rsp_o.route  = spep_pkg::ROUTE_FALLBACK;
          rsp_o.reason = spep_pkg::RSN_PENDING;
        end else if (!retry_open) begin
          rsp_o.route  = spep_pkg::ROUTE_FALLBACK;
          rsp_o.reason = spep_pkg::RSN_BACKOFF;
        end else if (!req_i.queue_space) begin
          rsp_o.route  = spep_pkg::ROUTE_FALLBACK;
          rsp_o.reason = spep_pkg::RSN_QFULL;
        end else begin
          rsp_o.route           = spep_pkg::ROUTE_FALLBACK;
          rsp_o.reason          = spep_pkg::RSN_ENQUEUE;
          rsp_o.request_compile = 1'b1;
        end
      end
      spep_pkg::REQ_MARK_PEND: begin
        if (req_i.req_ticket != '0) begin
          key_d          = req_key;
          gen_d          = req_i.req_generation;
          ticket_d       = req_i.req_ticket;
          retry_d        = '0;
          state_d        = spep_pkg::ST_PENDING;
          rsp_o.accepted = 1'b1;
        end
      end
      spep_pkg::REQ_MARK_FAIL: begin
        if (state_q == spep_pkg::ST_PENDING) begin
          state_d        = spep_pkg::ST_FAILED;
          retry_d        = retry_sat;
          ticket_d       = '0;
          rsp_o.accepted = 1'b1;
        end
      end
      spep_pkg::REQ_DEFER_FULL: begin
        key_d          = req_key;
        gen_d          = req_i.req_generation;
        ticket_d       = '0;
        retry_d        = retry_sat;
        state_d        = spep_pkg::ST_FAILED;
        rsp_o.accepted = 1'b1;
      end
      spep_pkg::REQ_PUBLISH: begin
        if (state_q != spep_pkg::ST_PENDING) begin
          rsp_o.publish_code = spep_pkg::PUB_NOT_PEND;
        end else if (req_i.parts_present[PCMP_W-1:0] != complete_parts_i) begin
          rsp_o.publish_code = spep_pkg::PUB_INCOMPLETE;
        end else if (key_q != req_key) begin
          rsp_o.publish_code = spep_pkg::PUB_KEY_MISM;
        end else if ((gen_q != req_i.current_gen) ||
                     (req_i.req_generation != req_i.current_gen)) begin
          rsp_o.publish_code = spep_pkg::PUB_GEN_MISM;
        end else if ((req_i.req_ticket == '0) || (ticket_q == '0)) begin
          rsp_o.publish_code = spep_pkg::PUB_BAD_TICKET;
        end else if (ticket_q != req_i.req_ticket) begin
          rsp_o.publish_code = spep_pkg::PUB_TICKET_MISM;
        end else begin
          rsp_o.publish_code = spep_pkg::PUB_OK;
          pub_ok             = 1'b1;
          state_d            = spep_pkg::ST_READY;
          retry_d            = '0;
          sel_d              = sel_inc;
        end
      end
      default: begin
        // unused request codes leave the entry alone
      end
    endcase

    rsp_o.selection_count = sel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= spep_pkg::ST_ABSENT;
      key_q    <= '0;
      gen_q    <= '0;
      ticket_q <= '0;
      retry_q  <= '0;
      sel_q    <= '0;
    end else if (fire_i) begin
      state_q  <= state_d;
      key_q    <= key_d;
      gen_q    <= gen_d;
      ticket_q <= ticket_d;
      retry_q  <= retry_d;
      sel_q    <= sel_d;
    end
  end

  // successful publish leaves the entry ready
  a_pub_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && pub_ok |=> state_q == spep_pkg::ST_READY)
    else $error("publish did not leave entry ready");

  // selection epoch moves only on a successful publish
  a_sel_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && pub_ok) |=> $stable(sel_q))
    else $error("selection epoch changed without publish");

  // once non-zero the selection epoch never returns to zero
  a_sel_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q != '0 |=> sel_q != '0)
    else $error("selection epoch wrapped to zero");

  // a pending entry always holds a valid ticket
  a_pend_ticket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == spep_pkg::ST_PENDING |-> ticket_q != '0)
    else $error("pending entry without ticket");

endmodule

@@ rtl/specialization_entry_policy_top.sv @@
// specialization_entry_policy_top: request input register, policy core, result register
// depends on spep_pkg, spep_if (channel interfaces) and spep_core
//
//  channel | dir | interface   | payload
//  --------+-----+-------------+------------------------------------------
//  req_i   | in  | spep_req_if | one request (choose, mark, defer, publish)
//  rsp_o   | out | spep_rsp_if | route, reason, flags, codes, selection epoch
//  cfg_i   | in  | spep_cfg_if | register index and write data
//
//  one request a cycle sustained while the result side takes results; a request's result is registered
//  (input register at acceptance, then result register once it has room), core in between
//  entry state is updated as a request moves from the input register to the result register
//  reset clears the entry to absent, the selection epoch to zero, backoff to one, parts to all ones
//  a stalled result holds the result register; the input register still takes one more request
//  configuration writes are always taken and apply from the next cycle

module specialization_entry_policy_top #(
  parameter int unsigned KEY_BITS   = spep_pkg::KEY_BITS_DEF,
  parameter int unsigned PARTS_BITS = spep_pkg::PARTS_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spep_req_if.sink   req_i,
  spep_rsp_if.source rsp_o,
  spep_cfg_if.sink   cfg_i
);

  // only the bits present in the parts field take part in the completeness check
  localparam int unsigned PCMP_W = (PARTS_BITS < spep_pkg::PARTS_FIELD_W) ?
                                   PARTS_BITS : spep_pkg::PARTS_FIELD_W;

  // configuration registers
  logic [spep_pkg::WORD_W-1:0] backoff_q;
  logic [PCMP_W-1:0]           parts_q;

  // input register
  logic           in_valid_q;
  spep_pkg::req_t in_data_q;

  // result register
  logic           out_valid_q;
  spep_pkg::rsp_t out_data_q;

  logic           req_acc;
  logic           advance;
  logic           fire;
  spep_pkg::rsp_t core_rsp;

  // the result register frees up when it is empty or being taken
  assign advance     = !out_valid_q || rsp_o.ready;
  assign fire        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;
  assign req_acc     = req_i.valid && req_i.ready;

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  assign cfg_i.ready = 1'b1;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backoff_q <= spep_pkg::BACKOFF_RESET;
      parts_q   <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        spep_pkg::CFG_BACKOFF: backoff_q <= cfg_i.wdata;
        spep_pkg::CFG_PARTS:   parts_q   <= cfg_i.wdata[PCMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_acc) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      in_data_q <= req_i.data;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= core_rsp;
    end
  end

  spep_core #(
    .KEY_BITS   (KEY_BITS),
    .PARTS_BITS (PARTS_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .req_i            (in_data_q),
    .backoff_i        (backoff_q),
    .complete_parts_i (parts_q),
    .rsp_o            (core_rsp)
  );

  // a held request moves on as soon as the result register has room
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && advance |=> out_valid_q)
    else $error("held request did not reach result register");

  // a compile request comes only with the fallback and enqueue outcome
  a_compile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.request_compile |->
      out_data_q.reason == spep_pkg::RSN_ENQUEUE &&
      out_data_q.route == spep_pkg::ROUTE_FALLBACK)
    else $error("compile request with wrong route or reason");

  // accepted and publish code never both set on one result
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.accepted |-> out_data_q.publish_code == spep_pkg::PUB_OK)
    else $error("accepted flag with a publish code");

endmodule

@@ dv/spep_policy_checker.sv @@
// spep_policy_checker: watches the request, result and configuration channels,
// predicts each result of the specialization entry policy and compares it
// depends on spep_pkg and the channel interfaces of spep_if
`timescale 1ns / 1ps

module spep_policy_checker #(
  parameter int unsigned KEY_BITS   = spep_pkg::KEY_BITS_DEF,
  parameter int unsigned PARTS_BITS = spep_pkg::PARTS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spep_req_if         req_i,
  spep_rsp_if         rsp_i,
  spep_cfg_if         cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned awaited_count_o
);

  localparam int unsigned WORD_W = spep_pkg::WORD_W;

  localparam logic [WORD_W-1:0] ALL_ONES   = '1;
  localparam logic [WORD_W-1:0] KEY_MASK   = ALL_ONES >> (WORD_W - KEY_BITS);
  localparam logic [WORD_W-1:0] PARTS_MASK = ALL_ONES >> (WORD_W - PARTS_BITS);

  // shadow of the entry and the registers
  logic [1:0]        ent_state;
  logic [WORD_W-1:0] ent_key, ent_gen, ent_ticket, retry_mark, sel_epoch;
  logic [WORD_W-1:0] backoff_reg;
  logic [7:0]        parts_reg;

  spep_pkg::rsp_t expected_q[$];

  initial mismatch_count_o = 0;

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  function automatic logic [WORD_W-1:0] retry_from(input logic [WORD_W-1:0] now);
    return (ALL_ONES - now < backoff_reg) ? ALL_ONES : now + backoff_reg;
  endfunction

  // apply one request to the shadow entry and work out its result
  task automatic apply_request(input spep_pkg::req_t r, output spep_pkg::rsp_t res);
    logic [WORD_W-1:0] key;
    logic              hit, may_retry;
    key = r.req_key & KEY_MASK;
    res = '0;
    case (r.req_type)
      spep_pkg::REQ_CHOOSE: begin
        hit = ent_state != spep_pkg::ST_ABSENT && ent_gen == r.req_generation &&
              ent_key == key;
        may_retry = !hit || (ent_state == spep_pkg::ST_FAILED && r.now_epoch >= retry_mark);
        if (hit && ent_state == spep_pkg::ST_READY) begin
          res.route = spep_pkg::ROUTE_SPECIAL; res.reason = spep_pkg::RSN_READY;
        end else if (!r.pipeline_ready) begin
          res.route = spep_pkg::ROUTE_SYNC; res.reason = spep_pkg::RSN_NO_PIPE;
        end else if (!r.draw_ready) begin
          res.route = spep_pkg::ROUTE_SYNC; res.reason = spep_pkg::RSN_NO_RES;
        end else if (hit && ent_state == spep_pkg::ST_PENDING) begin
          res.route = spep_pkg::ROUTE_FALLBACK; res.reason = spep_pkg::RSN_PENDING;
        end else if (!may_retry) begin
          res.route = spep_pkg::ROUTE_FALLBACK; res.reason = spep_pkg::RSN_BACKOFF;
        end else if (!r.queue_space) begin
          res.route = spep_pkg::ROUTE_FALLBACK; res.reason = spep_pkg::RSN_QFULL;
        end else begin
          res.route = spep_pkg::ROUTE_FALLBACK; res.reason = spep_pkg::RSN_ENQUEUE;
          res.request_compile = 1'b1;
        end
      end
      spep_pkg::REQ_MARK_PEND: begin
        if (r.req_ticket != '0) begin
          ent_key     = key;
          ent_gen     = r.req_generation;
          ent_ticket  = r.req_ticket;
          retry_mark  = '0;
          ent_state   = spep_pkg::ST_PENDING;
          res.accepted = 1'b1;
        end
      end
      spep_pkg::REQ_MARK_FAIL: begin
        if (ent_state == spep_pkg::ST_PENDING) begin
          ent_state   = spep_pkg::ST_FAILED;
          retry_mark  = retry_from(r.now_epoch);
          ent_ticket  = '0;
          res.accepted = 1'b1;
        end
      end
      spep_pkg::REQ_DEFER_FULL: begin
        ent_key     = key;
        ent_gen     = r.req_generation;
        ent_ticket  = '0;
        retry_mark  = retry_from(r.now_epoch);
        ent_state   = spep_pkg::ST_FAILED;
        res.accepted = 1'b1;
      end
      spep_pkg::REQ_PUBLISH: begin
        if (ent_state != spep_pkg::ST_PENDING)
          res.publish_code = spep_pkg::PUB_NOT_PEND;
        else if ((WORD_W'(r.parts_present) & PARTS_MASK) !=
                 (WORD_W'(parts_reg) & PARTS_MASK))
          res.publish_code = spep_pkg::PUB_INCOMPLETE;
        else if (ent_key != key)
          res.publish_code = spep_pkg::PUB_KEY_MISM;
        else if (ent_gen != r.current_gen || r.req_generation != r.current_gen)
          res.publish_code = spep_pkg::PUB_GEN_MISM;
        else if (r.req_ticket == '0 || ent_ticket == '0)
          res.publish_code = spep_pkg::PUB_BAD_TICKET;
        else if (ent_ticket != r.req_ticket)
          res.publish_code = spep_pkg::PUB_TICKET_MISM;
        else begin
          ent_state   = spep_pkg::ST_READY;
          retry_mark  = '0;
          sel_epoch   = sel_epoch + 1'b1;
          if (sel_epoch == '0) sel_epoch = WORD_W'(1);
          res.publish_code = spep_pkg::PUB_OK;
        end
      end
      default: ;
    endcase
    res.selection_count = sel_epoch;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spep_pkg::rsp_t want, res;
    if (!rst_ni) begin
      ent_state   = spep_pkg::ST_ABSENT;
      ent_key     = '0;
      ent_gen     = '0;
      ent_ticket  = '0;
      retry_mark  = '0;
      sel_epoch   = '0;
      backoff_reg = spep_pkg::BACKOFF_RESET;
      parts_reg   = '1;
      expected_q.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request behind it", rsp_i.data.selection_count, '0);
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.data.route !== want.route)
            report_mismatch("route", WORD_W'(rsp_i.data.route), WORD_W'(want.route));
          if (rsp_i.data.reason !== want.reason)
            report_mismatch("reason", WORD_W'(rsp_i.data.reason), WORD_W'(want.reason));
          if (rsp_i.data.request_compile !== want.request_compile)
            report_mismatch("request_compile", WORD_W'(rsp_i.data.request_compile),
                            WORD_W'(want.request_compile));
          if (rsp_i.data.accepted !== want.accepted)
            report_mismatch("accepted", WORD_W'(rsp_i.data.accepted),
                            WORD_W'(want.accepted));
          if (rsp_i.data.publish_code !== want.publish_code)
            report_mismatch("publish_code", WORD_W'(rsp_i.data.publish_code),
                            WORD_W'(want.publish_code));
          if (rsp_i.data.selection_count !== want.selection_count)
            report_mismatch("selection_count", rsp_i.data.selection_count,
                            want.selection_count);
        end
      end
      if (req_i.valid && req_i.ready) begin
        apply_request(req_i.data, res);
        expected_q.push_back(res);
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          spep_pkg::CFG_BACKOFF: backoff_reg = cfg_i.wdata;
          spep_pkg::CFG_PARTS:   parts_reg   = cfg_i.wdata[7:0];
          default: ;
        endcase
      end
    end
    awaited_count_o = expected_q.size();
  end

endmodule

@@ dv/specialization_entry_policy_top_test.sv @@
// specialization_entry_policy_top_test: stimulus, configuration phases and verdict
// depends on spep_pkg, spep_if, specialization_entry_policy_top and spep_policy_checker
`timescale 1ns / 1ps

module specialization_entry_policy_top_test;

  localparam int unsigned WORD_W = spep_pkg::WORD_W;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  // request type outside the defined set, must be ignored by the block
  localparam logic [2:0] REQ_UNKNOWN = 3'd7;
  // flag order is {pipeline_ready, draw_ready, queue_space}
  localparam logic [2:0] ALL_OK = 3'b111;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 95;

  logic clk_i;
  logic rst_ni;

  spep_req_if req_if ();
  spep_rsp_if rsp_if ();
  spep_cfg_if cfg_if ();

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int unsigned items_sent;
  int unsigned idle_cycles;

  // shared pacing flags: burst means neither side idles, hold asks the
  // result side for one long stall
  bit burst;
  bit hold_rsp;

  // what the stimulus believes the registers hold, to aim at the edges
  logic [WORD_W-1:0] backoff_now;
  logic [7:0]        parts_now;

  // small pools so that chooses and publishes hit the stored entry
  logic [WORD_W-1:0] key_pool[4];
  logic [WORD_W-1:0] gen_pool[4];

  specialization_entry_policy_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  spep_policy_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .cfg_i            (cfg_if),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly a pooled value, sometimes anything at all
  function automatic logic [WORD_W-1:0] pick_key();
    return ($urandom_range(0, 4) == 0) ? rand64() : key_pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [WORD_W-1:0] pick_gen();
    return ($urandom_range(0, 4) == 0) ? rand64() : gen_pool[$urandom_range(0, 3)];
  endfunction

  // base epoch: often close to the top so the retry epoch saturates
  function automatic logic [WORD_W-1:0] pick_epoch();
    case ($urandom_range(0, 4))
      0:       return ALL_ONES - $urandom_range(0, 3);
      1:       return WORD_W'($urandom_range(0, 3));
      default: return rand64();
    endcase
  endfunction

  // an epoch around the retry point that a failure at base sets up
  function automatic logic [WORD_W-1:0] near_retry(input logic [WORD_W-1:0] base);
    case ($urandom_range(0, 4))
      0:       return base;
      1:       return base + backoff_now - 1;
      2:       return base + backoff_now;
      3:       return base + backoff_now + 1;
      default: return rand64();
    endcase
  endfunction

  // mostly every resource present so the chain reaches its lower steps
  function automatic logic [2:0] pick_flags();
    return ($urandom_range(0, 3) == 0) ? 3'($urandom) : ALL_OK;
  endfunction

  function automatic spep_pkg::req_t shape(input logic [2:0] kind,
                                           input logic [WORD_W-1:0] key,
                                           input logic [WORD_W-1:0] gen,
                                           input logic [WORD_W-1:0] ticket,
                                           input logic [WORD_W-1:0] now,
                                           input logic [WORD_W-1:0] cur,
                                           input logic [2:0] flags, input logic [7:0] parts);
    spep_pkg::req_t r;
    r.req_type       = kind;
    r.req_key        = key;
    r.req_generation = gen;
    r.req_ticket     = ticket;
    r.now_epoch      = now;
    r.current_gen    = cur;
    r.pipeline_ready = flags[2];
    r.draw_ready     = flags[1];
    r.queue_space    = flags[0];
    r.parts_present  = parts;
    return r;
  endfunction

  // every field random, unknown request types included
  function automatic spep_pkg::req_t noise_req();
    return shape(3'($urandom_range(0, 7)), rand64(), rand64(), rand64(), rand64(),
                 rand64(), 3'($urandom), 8'($urandom));
  endfunction

  // offer one request after a drawn gap; valid stays up when the gap is zero
  task automatic send_req(input spep_pkg::req_t r);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  // drop valid and wait until every result is back and the pipe is empty
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_count != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input spep_pkg::cfg_idx_t idx, input logic [WORD_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    if (idx == spep_pkg::CFG_BACKOFF) backoff_now = value;
    else parts_now = value[7:0];
  endtask

  // directed sequence against the reset settings (backoff one, parts all ones)
  task automatic run_directed();
    // choose against an absent entry, walking down the priority chain
    send_req(shape(spep_pkg::REQ_CHOOSE, '0, '0, '0, '0, '0, 3'b011, '0));
    send_req(shape(spep_pkg::REQ_CHOOSE, '0, '0, '0, '0, '0, 3'b101, '0));
    send_req(shape(spep_pkg::REQ_CHOOSE, '0, '0, '0, '0, '0, 3'b110, '0));
    send_req(shape(spep_pkg::REQ_CHOOSE, '0, '0, '0, '0, '0, ALL_OK, '0));
    // unknown type leaves everything alone
    send_req(shape(REQ_UNKNOWN, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_OK,
                   8'hFF));
    // failure and publish with nothing pending are refused
    send_req(shape(spep_pkg::REQ_MARK_FAIL, '0, '0, '0, 64'd5, '0, ALL_OK, '0));
    send_req(shape(spep_pkg::REQ_PUBLISH, '0, '0, 64'd1, '0, '0, ALL_OK, 8'hFF));
    // zero ticket on mark pending is refused
    send_req(shape(spep_pkg::REQ_MARK_PEND, 64'd3, 64'd3, '0, '0, '0, ALL_OK, '0));
    send_req(shape(spep_pkg::REQ_MARK_PEND, ALL_ONES, ALL_ONES, ALL_ONES, '0, '0, ALL_OK,
                   '0));
    send_req(shape(spep_pkg::REQ_CHOOSE, ALL_ONES, ALL_ONES, '0, '0, '0, ALL_OK, '0));
    // each publish check in turn, then the good one
    send_req(shape(spep_pkg::REQ_PUBLISH, ALL_ONES, ALL_ONES, ALL_ONES, '0, ALL_ONES, ALL_OK,
                   8'h00));
    send_req(shape(spep_pkg::REQ_PUBLISH, '0, ALL_ONES, ALL_ONES, '0, ALL_ONES, ALL_OK,
                   8'hFF));
    send_req(shape(spep_pkg::REQ_PUBLISH, ALL_ONES, ALL_ONES, ALL_ONES, '0, '0, ALL_OK,
                   8'hFF));
    send_req(shape(spep_pkg::REQ_PUBLISH, ALL_ONES, '0, ALL_ONES, '0, ALL_ONES, ALL_OK,
                   8'hFF));
    send_req(shape(spep_pkg::REQ_PUBLISH, ALL_ONES, ALL_ONES, '0, '0, ALL_ONES, ALL_OK,
                   8'hFF));
    send_req(shape(spep_pkg::REQ_PUBLISH, ALL_ONES, ALL_ONES, 64'd5, '0, ALL_ONES, ALL_OK,
                   8'hFF));
    send_req(shape(spep_pkg::REQ_PUBLISH, ALL_ONES, ALL_ONES, ALL_ONES, '0, ALL_ONES, ALL_OK,
                   8'hFF));
    // a ready entry wins even with no pipeline or resources
    send_req(shape(spep_pkg::REQ_CHOOSE, ALL_ONES, ALL_ONES, '0, '0, '0, 3'b000, '0));
    // failure at the top epoch: retry epoch saturates
    send_req(shape(spep_pkg::REQ_MARK_PEND, 64'h5A, 64'd7, 64'd9, '0, '0, ALL_OK, '0));
    send_req(shape(spep_pkg::REQ_MARK_FAIL, '0, '0, '0, ALL_ONES, '0, ALL_OK, '0));
    send_req(shape(spep_pkg::REQ_CHOOSE, 64'h5A, 64'd7, '0, ALL_ONES - 1, '0, ALL_OK, '0));
    send_req(shape(spep_pkg::REQ_CHOOSE, 64'h5A, 64'd7, '0, ALL_ONES, '0, 3'b110, '0));
    // full queue deferral, then backoff and retry on either side of it
    send_req(shape(spep_pkg::REQ_DEFER_FULL, '0, '0, '0, '0, '0, ALL_OK, '0));
    send_req(shape(spep_pkg::REQ_CHOOSE, '0, '0, '0, '0, '0, ALL_OK, '0));
    send_req(shape(spep_pkg::REQ_CHOOSE, '0, '0, '0, 64'd1, '0, ALL_OK, '0));
  endtask

  // random part: mostly whole flows with random content, some noise
  task automatic run_random(input int unsigned count);
    int unsigned target, pick;
    logic [WORD_W-1:0] key, gen, ticket, base, cur;
    logic [7:0]        parts;
    target = items_sent + count;
    while (items_sent < target) begin
      if (items_sent % 25 == 0) burst = ($urandom_range(0, 3) == 0);
      key    = pick_key();
      gen    = pick_gen();
      ticket = ($urandom_range(0, 9) == 0) ? '0 : rand64();
      base   = pick_epoch();
      pick   = $urandom_range(0, 9);
      if (pick <= 2) begin
        // pending, then a publish that is sometimes spoilt in one check
        cur   = gen;
        parts = parts_now;
        send_req(shape(spep_pkg::REQ_MARK_PEND, key, gen, ticket, base, '0, ALL_OK, '0));
        if ($urandom_range(0, 1)) send_req(shape(spep_pkg::REQ_CHOOSE, key, gen, '0, base,
                                                 '0, pick_flags(), '0));
        case ($urandom_range(0, 9))
          0: parts  = 8'($urandom);
          1: key    = pick_key();
          2: cur    = pick_gen();
          3: ticket = '0;
          4: ticket = rand64();
          default: ;
        endcase
        send_req(shape(spep_pkg::REQ_PUBLISH, key, gen, ticket, base, cur, pick_flags(),
                       parts));
        send_req(shape(spep_pkg::REQ_CHOOSE, key, gen, '0, base, '0, pick_flags(), '0));
      end else if (pick <= 4) begin
        // pending, failed, then chooses around the retry point
        send_req(shape(spep_pkg::REQ_MARK_PEND, key, gen, ticket, base, '0, ALL_OK, '0));
        send_req(shape(spep_pkg::REQ_MARK_FAIL, rand64(), rand64(), rand64(), base, '0,
                       ALL_OK, '0));
        send_req(shape(spep_pkg::REQ_CHOOSE, key, gen, '0, near_retry(base), '0,
                       pick_flags(), '0));
        send_req(shape(spep_pkg::REQ_CHOOSE, key, gen, '0, near_retry(base), '0,
                       pick_flags(), '0));
      end else if (pick == 5) begin
        // full-queue deferral, a retry probe and a failure that must be refused
        send_req(shape(spep_pkg::REQ_DEFER_FULL, key, gen, rand64(), base, '0, ALL_OK, '0));
        send_req(shape(spep_pkg::REQ_CHOOSE, key, gen, '0, near_retry(base), '0,
                       pick_flags(), '0));
        send_req(shape(spep_pkg::REQ_MARK_FAIL, key, gen, ticket, base, '0, ALL_OK, '0));
      end else if (pick <= 7) begin
        send_req(shape(spep_pkg::REQ_CHOOSE, key, gen, rand64(), base, rand64(), pick_flags(),
                       8'($urandom)));
      end else begin
        send_req(noise_req());
      end
    end
  endtask

  // result side: drawn stalls, plus one long hold when asked
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_rsp) begin
        stall    = HOLD_CYCLES;
        hold_rsp = 1'b0;
      end else begin
        stall = burst ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // main sequence
  initial begin
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    rsp_if.ready <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= spep_pkg::CFG_BACKOFF;
    cfg_if.wdata <= '0;
    idle_cycles  = 0;
    items_sent   = 0;
    burst        = 1'b0;
    hold_rsp     = 1'b0;
    backoff_now  = spep_pkg::BACKOFF_RESET;
    parts_now    = 8'hFF;
    key_pool = '{64'h0, 64'h5A, ALL_ONES, rand64()};
    gen_pool = '{64'h0, 64'h7, ALL_ONES, rand64()};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    run_directed();
    run_random(PHASE_ITEMS);
    drain();

    // zero backoff and zero parts, with the long result hold
    write_reg(spep_pkg::CFG_BACKOFF, '0);
    write_reg(spep_pkg::CFG_PARTS, '0);
    hold_rsp = 1'b1;
    run_random(PHASE_ITEMS);
    drain();

    // largest backoff, all parts
    write_reg(spep_pkg::CFG_BACKOFF, ALL_ONES);
    write_reg(spep_pkg::CFG_PARTS, 64'hFF);
    run_random(PHASE_ITEMS);
    drain();

    // random settings, small backoff so that retries come round
    write_reg(spep_pkg::CFG_BACKOFF, WORD_W'($urandom_range(2, 20)));
    write_reg(spep_pkg::CFG_PARTS, WORD_W'(8'($urandom)));
    run_random(PHASE_ITEMS);
    drain();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/spep_pkg.sv
rtl/spep_if.sv
rtl/spep_core.sv
rtl/specialization_entry_policy_top.sv
dv/spep_policy_checker.sv
dv/specialization_entry_policy_top_test.sv
